@@ rtl/evp_pkg.sv @@
// ----------------------------------------------------------------------------
// evp_pkg: shared types and constants of the encoder velocity PID unit
// Register map, configuration bundle, controller/datapath handshake types.
// ----------------------------------------------------------------------------
package evp_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_RATE_MS   = 3'd0,
    REG_VEL_SCALE = 3'd1,
    REG_GOAL_VEL  = 3'd2,
    REG_KP_GAIN   = 3'd3,
    REG_KI_GAIN   = 3'd4,
    REG_KD_GAIN   = 3'd5,
    REG_PWM_MAX   = 3'd6,
    REG_PWM_MIN   = 3'd7
  } reg_idx_t;

  localparam logic [9:0]         RST_RATE_MS   = 10'd10;
  localparam logic [15:0]        RST_VEL_SCALE = 16'd730;
  localparam logic signed [23:0] RST_GOAL_VEL  = 24'sd0;
  localparam logic [15:0]        RST_KP_GAIN   = 16'd256;
  localparam logic [15:0]        RST_KI_GAIN   = 16'd0;
  localparam logic [15:0]        RST_KD_GAIN   = 16'd0;
  localparam logic [7:0]         RST_PWM_MAX   = 8'd255;
  localparam logic signed [8:0]  RST_PWM_MIN   = -9'sd255;

  typedef struct packed {
    logic [9:0]         rate_ms;
    logic [15:0]        vel_scale;
    logic signed [23:0] goal_vel;
    logic [15:0]        kp_gain;
    logic [15:0]        ki_gain;
    logic [15:0]        kd_gain;
    logic [7:0]         pwm_max;
    logic signed [8:0]  pwm_min;
  } cfg_t;

  // datapath operations, one per controller step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_EVENT,
    OP_MUL_VEL,
    OP_ERR,
    OP_MUL_KI,
    OP_INTEG,
    OP_MUL_KD,
    OP_SUM,
    OP_UPART,
    OP_DRIVE,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_VEL,
    ST_ERR,
    ST_MUL_KI,
    ST_INTEG,
    ST_MUL_KD,
    ST_SUM,
    ST_UPART,
    ST_DRIVE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic fire;   // the tick being accepted starts an update
  } dp_status_t;

endpackage

@@ rtl/evp_regs.sv @@
// ----------------------------------------------------------------------------
// evp_regs: configuration register file
// APB-style write/read port holding the eight control registers.
// ----------------------------------------------------------------------------
module evp_regs
  import evp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_ms   <= RST_RATE_MS;
      cfg.vel_scale <= RST_VEL_SCALE;
      cfg.goal_vel  <= RST_GOAL_VEL;
      cfg.kp_gain   <= RST_KP_GAIN;
      cfg.ki_gain   <= RST_KI_GAIN;
      cfg.kd_gain   <= RST_KD_GAIN;
      cfg.pwm_max   <= RST_PWM_MAX;
      cfg.pwm_min   <= RST_PWM_MIN;
    end else if (wr_en) begin
      case (idx)
        REG_RATE_MS:   cfg.rate_ms   <= pwdata[9:0];
        REG_VEL_SCALE: cfg.vel_scale <= pwdata[15:0];
        REG_GOAL_VEL:  cfg.goal_vel  <= pwdata[23:0];
        REG_KP_GAIN:   cfg.kp_gain   <= pwdata[15:0];
        REG_KI_GAIN:   cfg.ki_gain   <= pwdata[15:0];
        REG_KD_GAIN:   cfg.kd_gain   <= pwdata[15:0];
        REG_PWM_MAX:   cfg.pwm_max   <= pwdata[7:0];
        REG_PWM_MIN:   cfg.pwm_min   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // signed registers read back sign-extended
  always_comb begin
    case (idx)
      REG_RATE_MS:   prdata = {22'd0, cfg.rate_ms};
      REG_VEL_SCALE: prdata = {16'd0, cfg.vel_scale};
      REG_GOAL_VEL:  prdata = {{8{cfg.goal_vel[23]}}, cfg.goal_vel};
      REG_KP_GAIN:   prdata = {16'd0, cfg.kp_gain};
      REG_KI_GAIN:   prdata = {16'd0, cfg.ki_gain};
      REG_KD_GAIN:   prdata = {16'd0, cfg.kd_gain};
      REG_PWM_MAX:   prdata = {24'd0, cfg.pwm_max};
      REG_PWM_MIN:   prdata = {{23{cfg.pwm_min[8]}}, cfg.pwm_min};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/evp_ctrl.sv @@
// ----------------------------------------------------------------------------
// evp_ctrl: sequencing controller
// Accepts one event at a time, steps the datapath through an update when a
// tick fires, and hands the result to the output register.
// ----------------------------------------------------------------------------
module evp_ctrl
  import evp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        accept;
  logic        out_free;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = status.fire ? ST_MUL_VEL : ST_EMIT;
        end
      end
      ST_MUL_VEL: state_next = ST_ERR;
      ST_ERR:     state_next = ST_MUL_KI;
      ST_MUL_KI:  state_next = ST_INTEG;
      ST_INTEG:   state_next = ST_MUL_KD;
      ST_MUL_KD:  state_next = ST_SUM;
      ST_SUM:     state_next = ST_UPART;
      ST_UPART:   state_next = ST_DRIVE;
      ST_DRIVE:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd.op   = OP_NONE;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.op   = s_tvalid ? OP_EVENT : OP_NONE;
      end
      ST_MUL_VEL: cmd.op = OP_MUL_VEL;
      ST_ERR:     cmd.op = OP_ERR;
      ST_MUL_KI:  cmd.op = OP_MUL_KI;
      ST_INTEG:   cmd.op = OP_INTEG;
      ST_MUL_KD:  cmd.op = OP_MUL_KD;
      ST_SUM:     cmd.op = OP_SUM;
      ST_UPART:   cmd.op = OP_UPART;
      ST_DRIVE:   cmd.op = OP_DRIVE;
      ST_EMIT:    cmd.op = out_free ? OP_EMIT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_edge_goes_to_emit: assert property (@(posedge clk) disable iff (rst)
    (accept && !status.fire) |=> (state == ST_EMIT))
    else $error("non-update event did not go straight to emit");

  a_fire_starts_update: assert property (@(posedge clk) disable iff (rst)
    (accept && status.fire) |=> (state == ST_MUL_VEL))
    else $error("firing tick did not start an update");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && m_tvalid && !m_tready) |=> (state == ST_EMIT && m_tvalid))
    else $error("pending result overwritten while stalled");

endmodule

@@ rtl/evp_dp.sv @@
// ----------------------------------------------------------------------------
// evp_dp: encoder counter and PID datapath
// Position and tick counters, one shared 33x17 multiplier, PID accumulators
// and the result register.
// ----------------------------------------------------------------------------
module evp_dp
  import evp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  cfg_t               cfg,
  input  logic               kind,
  input  logic               enc_a,
  input  logic               enc_b,
  output dp_status_t         status,
  output logic signed [8:0]  drive,
  output logic [7:0]         duty,
  output logic               reverse,
  output logic signed [23:0] velocity,
  output logic signed [31:0] position,
  output logic               updated
);

  localparam logic signed [49:0] P_MAX24 = 50'sd8388607;
  localparam logic signed [49:0] P_MIN24 = -50'sd8388608;
  localparam logic signed [24:0] E_MAX24 = 25'sd8388607;
  localparam logic signed [24:0] E_MIN24 = -25'sd8388608;

  // model state
  logic signed [31:0] enc_count, count_at_last;
  logic [10:0]        elapsed;
  logic signed [23:0] meas_vel, integrator, last_error;
  logic signed [8:0]  drive_reg;
  logic               upd;

  // work registers
  logic signed [31:0] delta_r;
  logic signed [23:0] err_r;
  logic signed [24:0] diff_r;
  logic signed [49:0] prod;
  logic signed [50:0] acc;
  logic signed [43:0] u_r;

  logic [10:0]        elapsed_inc;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [23:0] vel_sat;
  logic signed [24:0] err_raw;
  logic signed [23:0] err_sat;
  logic signed [49:0] ki_term, isum, int_hi, int_lo;
  logic signed [49:0] int_new;
  logic signed [50:0] acc_div;
  logic signed [43:0] q;
  logic signed [43:0] drv_hi, drv_lo;
  logic signed [8:0]  drv_new;
  logic signed [9:0]  duty_sum;

  assign elapsed_inc = (elapsed == 11'h7FF) ? elapsed : elapsed + 11'd1;
  assign status.fire = kind && (elapsed_inc > {1'b0, cfg.rate_ms});

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_MUL_VEL: begin
        mul_a = {delta_r[31], delta_r};
        mul_b = {1'b0, cfg.vel_scale};
      end
      OP_MUL_KI: begin
        mul_a = 33'(err_r);
        mul_b = {1'b0, cfg.ki_gain};
      end
      OP_INTEG: begin
        mul_a = 33'(err_r);
        mul_b = {1'b0, cfg.kp_gain};
      end
      OP_MUL_KD: begin
        mul_a = 33'(diff_r);
        mul_b = {1'b0, cfg.kd_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = 50'(mul_a) * 50'(mul_b);

  // velocity and error saturation
  always_comb begin
    if (prod > P_MAX24) begin
      vel_sat = 24'sh7FFFFF;
    end else if (prod < P_MIN24) begin
      vel_sat = 24'sh800000;
    end else begin
      vel_sat = prod[23:0];
    end
    err_raw = 25'(cfg.goal_vel) - 25'(vel_sat);
    if (err_raw > E_MAX24) begin
      err_sat = 24'sh7FFFFF;
    end else if (err_raw < E_MIN24) begin
      err_sat = 24'sh800000;
    end else begin
      err_sat = err_raw[23:0];
    end
  end

  // integrator: truncate toward zero, then clamp (upper limit tested first)
  always_comb begin
    ki_term = (prod < 0) ? ((prod + 50'sd255) >>> 8) : (prod >>> 8);
    isum    = ki_term + 50'(integrator);
    int_hi  = 50'($signed({1'b0, cfg.pwm_max, 8'd0}));
    int_lo  = 50'($signed({cfg.pwm_min, 8'd0}));
    if (isum > int_hi) begin
      int_new = int_hi;
    end else if (isum < int_lo) begin
      int_new = int_lo;
    end else begin
      int_new = isum;
    end
  end

  always_comb begin
    acc_div = (acc < 0) ? ((acc + 51'sd255) >>> 8) : (acc >>> 8);
    q       = (u_r < 0) ? ((u_r + 44'sd255) >>> 8) : (u_r >>> 8);
    drv_hi  = 44'($signed({1'b0, cfg.pwm_max}));
    drv_lo  = 44'(cfg.pwm_min);
    if (q > drv_hi) begin
      drv_new = $signed({1'b0, cfg.pwm_max});
    end else if (q < drv_lo) begin
      drv_new = cfg.pwm_min;
    end else begin
      drv_new = q[8:0];
    end
    duty_sum = 10'sd255 + 10'(drive_reg);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_count     <= '0;
      count_at_last <= '0;
      elapsed       <= '0;
      meas_vel      <= '0;
      integrator    <= '0;
      last_error    <= '0;
      drive_reg     <= '0;
      upd           <= 1'b0;
    end else begin
      case (cmd.op)
        OP_EVENT: begin
          upd <= status.fire;
          if (!kind) begin
            // quadrature direction from the channel levels
            enc_count <= (enc_a == enc_b) ? enc_count + 32'sd1 : enc_count - 32'sd1;
          end else begin
            elapsed <= status.fire ? 11'd0 : elapsed_inc;
          end
        end
        OP_MUL_VEL: count_at_last <= enc_count;
        OP_ERR:     meas_vel      <= vel_sat;
        OP_INTEG:   integrator    <= int_new[23:0];
        OP_DRIVE: begin
          drive_reg  <= drv_new;
          last_error <= err_r;
        end
        default: ;
      endcase
    end
  end

  // work and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_EVENT:   delta_r <= enc_count - count_at_last;
      OP_MUL_VEL: prod    <= mul_p;
      OP_ERR:     err_r   <= err_sat;
      OP_MUL_KI: begin
        prod   <= mul_p;
        diff_r <= 25'(err_r) - 25'(last_error);
      end
      OP_INTEG:   prod <= mul_p;
      OP_MUL_KD: begin
        acc  <= 51'(prod);
        prod <= mul_p;
      end
      OP_SUM:     acc <= acc + 51'(prod);
      OP_UPART:   u_r <= acc_div[43:0] + 44'(integrator);
      OP_EMIT: begin
        drive    <= drive_reg;
        reverse  <= drive_reg[8];
        if (!drive_reg[8]) begin
          duty <= drive_reg[7:0];
        end else if (duty_sum[9]) begin
          duty <= 8'd0;
        end else begin
          duty <= duty_sum[7:0];
        end
        velocity <= meas_vel;
        position <= enc_count;
        updated  <= upd;
      end
      default: ;
    endcase
  end

  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_INTEG && int_lo <= int_hi) |=>
      (50'(integrator) <= $past(int_hi) && 50'(integrator) >= $past(int_lo)))
    else $error("integrator left its limits");

  a_elapsed_bounded: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EVENT && kind) |=> (elapsed <= {1'b0, $past(cfg.rate_ms)}))
    else $error("elapsed tick count passed the update period");

endmodule

@@ rtl/encoder_velocity_pid_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_velocity_pid_unit: quadrature encoder counter with PID speed loop
//
// Slave stream carries events: s_tuser = kind (0 encoder edge, 1 ms tick),
// s_tdata = {enc_b, enc_a}. Every accepted event yields exactly one result on
// the master stream: drive, duty, direction, last velocity, position and an
// updated flag in m_tuser.
// An edge event, or a tick that does not close the update period, goes from
// idle straight to the emit step, which registers the result and raises
// m_tvalid. A tick that runs an update steps through the PID states before
// the emit step: the PID steps pass four times through one shared 33x17
// multiplier, with add, truncate and clamp steps.
// One event is in flight at a time; s_tready is high while the controller
// is idle, also while a finished result still waits in the output register.
// If the receiver stalls, the next event is still taken and processed, and
// its result waits in the last step until the output register frees up.
// Synchronous reset clears counters, PID state, the pending result and
// restores the register defaults. Registers are written over APB at byte
// address 4 * index; the user must do so with no event in flight, unenforced.
// ----------------------------------------------------------------------------
module encoder_velocity_pid_unit
  import evp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // event stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [0] enc_a, [1] enc_b, [7:2] zero
  input  logic [0:0]        s_tuser,   // [0] kind
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [79:0]       m_tdata,   // [8:0] drive, [16:9] duty, [17] reverse,
                                       // [41:18] velocity, [73:42] position, zero above
  output logic [0:0]        m_tuser,   // [0] updated
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t               cfg;
  dp_cmd_t            cmd;
  dp_status_t         status;
  logic signed [8:0]  drive;
  logic [7:0]         duty;
  logic               reverse;
  logic signed [23:0] velocity;
  logic signed [31:0] position;
  logic               updated;

  evp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  evp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  evp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .kind     (s_tuser[0]),
    .enc_a    (s_tdata[0]),
    .enc_b    (s_tdata[1]),
    .status   (status),
    .drive    (drive),
    .duty     (duty),
    .reverse  (reverse),
    .velocity (velocity),
    .position (position),
    .updated  (updated)
  );

  assign m_tdata = {6'd0, position, velocity, reverse, duty, drive};
  assign m_tuser = updated;

endmodule
